[rtl/lst_pkg.sv]
// shared constants and types of the range-add range-sum store
package lst_pkg;

  localparam int unsigned NUM_ELEMENTS = 1024;
  localparam int unsigned ADDR_W       = $clog2(NUM_ELEMENTS);
  localparam int unsigned IDX_W        = ADDR_W + 2;
  localparam int unsigned RANGE_W      = 10;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned SUM_W        = 64;
  localparam int unsigned STAT_W       = 2;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] STAT_ADD   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_QUERY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic rd;
    logic step;
    logic mul;
    logic setup;
    logic fold;
    logic out_load;
    logic pass;
  } lst_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_add;
    logic live;
    logic clr_last;
  } lst_sts_t;

endpackage

[rtl/lst_if.sv]
// request and response channel interfaces
interface lst_req_if;
  import lst_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [RANGE_W-1:0] range_low;
  logic [RANGE_W-1:0] range_high;
  logic signed [VAL_W-1:0] add_value;
  modport source (output valid, req_type, range_low, range_high, add_value, input ready);
  modport sink   (input valid, req_type, range_low, range_high, add_value, output ready);
endinterface

interface lst_rsp_if;
  import lst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] range_sum;
  logic [STAT_W-1:0]       status;
  modport source (output valid, range_sum, status, input ready);
  modport sink   (input valid, range_sum, status, output ready);
endinterface

[rtl/lst_dpath.sv]
// datapath: two fenwick tree memories, index walker, multiplier and result register
module lst_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lst_pkg::lst_cmd_t             cmd_i,
  input  logic                          req_type_i,
  input  logic [lst_pkg::RANGE_W-1:0]   range_low_i,
  input  logic [lst_pkg::RANGE_W-1:0]   range_high_i,
  input  logic signed [lst_pkg::VAL_W-1:0] add_value_i,
  output lst_pkg::lst_sts_t             sts_o,
  output logic signed [lst_pkg::SUM_W-1:0] range_sum_o,
  output logic [lst_pkg::STAT_W-1:0]    status_o
);
  import lst_pkg::*;

  logic [SUM_W-1:0] mem1 [NUM_ELEMENTS];
  logic [SUM_W-1:0] mem2 [NUM_ELEMENTS];

  logic               type_q;
  logic [RANGE_W-1:0] low_q, high_q;
  logic [VAL_W-1:0]   d_q;
  logic [IDX_W-1:0]   idx_q;
  logic [ADDR_W-1:0]  clr_q;
  logic [SUM_W-1:0]   dl1_q, dl2_q, acc1_q, acc2_q, rd1_q, rd2_q, mul_q, part_q;
  logic [SUM_W-1:0]   sum_q;
  logic [STAT_W-1:0]  stat_q;

  logic               is_add;
  logic               bad;
  logic [IDX_W-1:0]   pidx;
  logic [IDX_W-1:0]   lowbit;
  logic [SUM_W-1:0]   d_ext;
  logic [SUM_W-1:0]   opa;
  logic [SUM_W-1:0]   fold_val;
  logic [ADDR_W-1:0]  addr;
  logic               wr_en;
  logic [SUM_W-1:0]   wr1, wr2;

  assign is_add   = (type_q == REQ_ADD);
  assign bad      = (low_q > high_q) || (IDX_W'(high_q) >= IDX_W'(NUM_ELEMENTS));
  // prefix point of the pass: low for the first, high+1 for the second
  assign pidx     = cmd_i.pass ? (IDX_W'(high_q) + IDX_W'(1)) : IDX_W'(low_q);
  assign lowbit   = idx_q & (~idx_q + IDX_W'(1));
  assign d_ext    = SUM_W'(signed'(d_q));
  assign opa      = is_add ? d_ext : acc1_q;
  assign fold_val = mul_q - acc2_q;
  assign addr     = cmd_i.clr_wr ? clr_q : idx_q[ADDR_W-1:0];
  assign wr_en    = cmd_i.clr_wr || (cmd_i.step && is_add);
  assign wr1      = cmd_i.clr_wr ? '0 : rd1_q + dl1_q;
  assign wr2      = cmd_i.clr_wr ? '0 : rd2_q + dl2_q;

  assign sts_o.bad      = bad;
  assign sts_o.is_add   = is_add;
  assign sts_o.live     = (idx_q != '0) && (!is_add || idx_q <= IDX_W'(NUM_ELEMENTS));
  assign sts_o.clr_last = (clr_q == {ADDR_W{1'b1}});

  assign range_sum_o = sum_q;
  assign status_o    = stat_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem1[addr] <= wr1;
      mem2[addr] <= wr2;
    end
    if (cmd_i.rd) begin
      rd1_q <= mem1[addr];
      rd2_q <= mem2[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= req_type_i;
      low_q  <= range_low_i;
      high_q <= range_high_i;
      d_q    <= add_value_i;
    end
    if (cmd_i.mul) begin
      mul_q <= SUM_W'(opa * pidx);
    end
    if (cmd_i.setup) begin
      idx_q  <= pidx + (is_add ? IDX_W'(1) : IDX_W'(0));
      dl1_q  <= cmd_i.pass ? (SUM_W'(0) - d_ext) : d_ext;
      dl2_q  <= cmd_i.pass ? (SUM_W'(0) - mul_q) : mul_q;
      acc1_q <= '0;
      acc2_q <= '0;
    end else if (cmd_i.step) begin
      if (is_add) begin
        idx_q <= idx_q + lowbit;
      end else begin
        idx_q  <= idx_q - lowbit;
        acc1_q <= acc1_q + rd1_q;
        acc2_q <= acc2_q + rd2_q;
      end
    end
    if (cmd_i.fold) begin
      part_q <= cmd_i.pass ? (part_q + fold_val) : (SUM_W'(0) - fold_val);
    end
    if (cmd_i.out_load) begin
      sum_q  <= (!bad && !is_add) ? part_q : '0;
      stat_q <= bad ? STAT_BAD : (is_add ? STAT_ADD : STAT_QUERY);
    end
  end

endmodule

[rtl/lst_ctrl.sv]
// controller: clearing sweep and sequencing of the tree walks
module lst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  lst_pkg::lst_sts_t   sts_i,
  output lst_pkg::lst_cmd_t   cmd_o
);
  import lst_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_MUL, S_SETUP, S_RD, S_STEP, S_FOLD, S_DONE
  } state_e;

  state_e state_q;
  logic   pass_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.pass     = pass_q;
    cmd_o.load     = in_ready_o && in_valid_i;
    cmd_o.clr_wr   = (state_q == S_CLEAR);
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.setup    = (state_q == S_SETUP);
    cmd_o.rd       = (state_q == S_RD) && sts_i.live;
    cmd_o.step     = (state_q == S_STEP);
    cmd_o.fold     = (state_q == S_FOLD);
    cmd_o.out_load = (state_q == S_DONE) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (sts_i.clr_last) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            pass_q  <= 1'b0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts_i.bad) state_q <= S_DONE;
          else if (sts_i.is_add) state_q <= S_MUL;
          else state_q <= S_SETUP;
        end
        S_MUL: begin
          state_q <= sts_i.is_add ? S_SETUP : S_FOLD;
        end
        S_SETUP: begin
          state_q <= S_RD;
        end
        S_RD: begin
          if (sts_i.live) begin
            state_q <= S_STEP;
          end else if (!sts_i.is_add) begin
            state_q <= S_MUL;
          end else if (pass_q) begin
            state_q <= S_DONE;
          end else begin
            pass_q  <= 1'b1;
            state_q <= S_MUL;
          end
        end
        S_STEP: begin
          state_q <= S_RD;
        end
        S_FOLD: begin
          if (pass_q) begin
            state_q <= S_DONE;
          end else begin
            pass_q  <= 1'b1;
            state_q <= S_SETUP;
          end
        end
        S_DONE: begin
          if (slot_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/lazy_segment_tree_range_add_sum.sv]
// top level of the range-add range-sum store
// range-add / range-sum store over NUM_ELEMENTS signed elements, all zero after
// reset, held as two fenwick trees in single-port memories (values and
// index-weighted values). after reset the block sweeps both memories to zero,
// one entry a cycle, with req ready low. each request then takes one item at a
// time: an add walks two update passes and a query two prefix passes, each
// pass a read step and an index step per tree level visited (up to
// log2(NUM_ELEMENTS)+1 levels), plus states for the range check, the 64x12
// multiply and the fold. a bad range (low above high or high past the end)
// answers from the range check with status bad and a zero sum. a finished
// result waits in an output register while the next item is taken; sums wrap
// modulo 2^64
module lazy_segment_tree_range_add_sum (
  input  logic      clk_i,
  input  logic      rst_ni,
  lst_req_if.sink   req_i,
  lst_rsp_if.source rsp_o
);
  import lst_pkg::*;

  lst_cmd_t cmd;
  lst_sts_t sts;

  lst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lst_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req_i.req_type),
    .range_low_i  (req_i.range_low),
    .range_high_i (req_i.range_high),
    .add_value_i  (req_i.add_value),
    .sts_o        (sts),
    .range_sum_o  (rsp_o.range_sum),
    .status_o     (rsp_o.status)
  );

  // one item in flight: no new item right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("item accepted while previous one in flight");

  // a non-query result carries a zero sum
  a_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != STAT_QUERY) |-> (rsp_o.range_sum == '0))
    else $error("nonzero sum on add or rejected item");

  // no update step, no result load and no req ready in the same cycle as the clearing sweep
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> (!req_i.ready && !cmd.out_load && !cmd.step))
    else $error("activity during clearing sweep");

endmodule

[tb/tb_lazy_segment_tree_range_add_sum.sv]
// testbench of the range-add range-sum store: directed and random requests against a flat model
`timescale 1ns / 100ps

module tb_lazy_segment_tree_range_add_sum;
  import lst_pkg::*;

  typedef struct packed {
    logic               req_type;
    logic [RANGE_W-1:0] range_low;
    logic [RANGE_W-1:0] range_high;
    logic [VAL_W-1:0]   add_value;
  } req_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]  range_sum;
    logic [STAT_W-1:0] status;
  } rsp_item_t;

  logic clk_i;
  logic rst_ni;

  lst_req_if req_if ();
  lst_rsp_if rsp_if ();

  lazy_segment_tree_range_add_sum u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // flat copy of the element array; the tree only changes how sums are formed
  logic [SUM_W-1:0] elem_values [NUM_ELEMENTS];
  rsp_item_t        pending_rsps [$];
  int               fail_count;
  bit               hold_off;     // long receiver stall requested
  bit               hold_active;  // stall is in progress

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // expected result of one request, updating the flat array for adds
  function automatic rsp_item_t predict_range_op(req_item_t r);
    rsp_item_t        res;
    logic [SUM_W-1:0] d;
    logic [SUM_W-1:0] acc;
    acc = '0;
    d   = {{(SUM_W-VAL_W){r.add_value[VAL_W-1]}}, r.add_value};
    res = '0;
    if (r.range_low > r.range_high || r.range_high >= NUM_ELEMENTS) begin
      res.status = STAT_BAD;
    end else if (r.req_type == REQ_ADD) begin
      for (int i = r.range_low; i <= r.range_high; i++) elem_values[i] += d;
      res.status = STAT_ADD;
    end else begin
      for (int i = r.range_low; i <= r.range_high; i++) acc += elem_values[i];
      res.range_sum = acc;
      res.status    = STAT_QUERY;
    end
    return res;
  endfunction

  function automatic int rand_gap();
    // mostly back to back or short, now and then a long pause
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 95) return $urandom_range(4, 1);
    return $urandom_range(60, 10);
  endfunction

  // offer one item, wait for acceptance, then drop valid for a gap if any
  task automatic send_request(req_item_t r, bit no_gap = 1'b0);
    int gap;
    req_if.valid      <= 1'b1;
    req_if.req_type   <= r.req_type;
    req_if.range_low  <= r.range_low;
    req_if.range_high <= r.range_high;
    req_if.add_value  <= r.add_value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_rsps.push_back(predict_range_op(r));
    gap = no_gap ? 0 : rand_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic req_item_t make_req(logic kind, int lo, int hi, logic [VAL_W-1:0] v);
    req_item_t r;
    r.req_type   = kind;
    r.range_low  = RANGE_W'(lo);
    r.range_high = RANGE_W'(hi);
    r.add_value  = v;
    return r;
  endfunction

  // random item: mostly valid ranges, many short, some reversed
  function automatic req_item_t rand_req();
    req_item_t r;
    int        lo;
    int        hi;
    int        p;
    p  = $urandom_range(99);
    lo = $urandom_range(NUM_ELEMENTS-1);
    if (p < 40) hi = lo + $urandom_range(8);
    else if (p < 90) hi = $urandom_range(NUM_ELEMENTS-1, lo);
    else hi = $urandom_range(NUM_ELEMENTS-1);
    if (hi > NUM_ELEMENTS-1) hi = NUM_ELEMENTS-1;
    r.req_type   = 1'($urandom_range(1));
    r.range_low  = RANGE_W'(lo);
    r.range_high = RANGE_W'(hi);
    // wide values drive the sums into wrapping
    r.add_value  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200) - 100;
    return r;
  endfunction

  // response checker; the receiver idles at random or holds off on request
  initial begin : rsp_checker
    rsp_item_t exp_rsp;
    int        gap;
    rsp_if.ready <= 1'b0;
    hold_active = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        // long stall counted here while the sender keeps offering
        hold_active = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off    = 1'b0;
        hold_active = 1'b0;
      end
      gap = rand_gap();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      if (rsp_if.valid) begin
        if (pending_rsps.size() == 0) begin
          $error("result with no request outstanding: sum %h status %0d",
                 rsp_if.range_sum, rsp_if.status);
          fail_count++;
        end else begin
          exp_rsp = pending_rsps.pop_front();
          if (rsp_if.range_sum !== exp_rsp.range_sum) begin
            $error("range_sum expected %h actual %h", exp_rsp.range_sum, rsp_if.range_sum);
            fail_count++;
          end
          if (rsp_if.status !== exp_rsp.status) begin
            $error("status expected %0d actual %0d", exp_rsp.status, rsp_if.status);
            fail_count++;
          end
        end
      end
    end
  end

  // extremes, both kinds, reversed ranges, wrapping
  task automatic test_directed();
    send_request(make_req(REQ_QUERY, 0, NUM_ELEMENTS-1, '0));
    send_request(make_req(REQ_ADD, 0, NUM_ELEMENTS-1, 32'h7fff_ffff));
    send_request(make_req(REQ_ADD, 0, 0, 32'h8000_0000));
    send_request(make_req(REQ_ADD, NUM_ELEMENTS-1, NUM_ELEMENTS-1, 32'hffff_ffff));
    send_request(make_req(REQ_QUERY, 0, 0, '0));
    send_request(make_req(REQ_QUERY, NUM_ELEMENTS-1, NUM_ELEMENTS-1, 32'hffff_ffff));
    send_request(make_req(REQ_QUERY, 0, NUM_ELEMENTS-1, '0));
    send_request(make_req(REQ_ADD, 5, 4, 32'h1234_5678));
    send_request(make_req(REQ_QUERY, 1023, 0, '0));
    send_request(make_req(REQ_ADD, 0, 1023, 32'h8000_0000));
    send_request(make_req(REQ_QUERY, 0, 1023, '0));
    send_request(make_req(REQ_ADD, 1, 1022, 32'h0000_0001));
    send_request(make_req(REQ_QUERY, 511, 512, '0));
    send_request(make_req(REQ_ADD, 512, 1023, 32'hffff_fffe));
    send_request(make_req(REQ_QUERY, 0, 1023, '0));
    send_request(make_req(REQ_QUERY, 300, 300, '0));
    // raise the full sum with repeated maximum adds
    repeat (4) send_request(make_req(REQ_ADD, 0, 1023, 32'h7fff_ffff));
    send_request(make_req(REQ_QUERY, 0, 1023, '0));
  endtask

  // receiver stalls long while back-to-back items fill the block
  task automatic test_backpressure();
    hold_off = 1'b1;
    wait (hold_active);
    repeat (8) send_request(rand_req(), 1'b1);
  endtask

  task automatic test_random(int count);
    repeat (count) send_request(rand_req());
  endtask

  initial begin : stimulus
    int drain;
    fail_count = 0;
    hold_off   = 1'b0;
    foreach (elem_values[i]) elem_values[i] = '0;
    rst_ni            = 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_ADD;
    req_if.range_low  <= '0;
    req_if.range_high <= '0;
    req_if.add_value  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_random(1800);
    req_if.valid <= 1'b0;

    drain = 0;
    while (pending_rsps.size() != 0 && drain < 200000) begin
      @(posedge clk_i);
      drain++;
    end
    if (pending_rsps.size() != 0) begin
      $error("%0d results never arrived", pending_rsps.size());
      fail_count++;
    end
    // catch any stray late result
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lst_pkg.sv
rtl/lst_if.sv
rtl/lst_dpath.sv
rtl/lst_ctrl.sv
rtl/lazy_segment_tree_range_add_sum.sv
tb/tb_lazy_segment_tree_range_add_sum.sv
